### hw/rtl/mps_pkg.sv
`timescale 1ns / 1ps

package mps_pkg;

    localparam int unsigned SLOT_COUNT = 8;
    localparam int unsigned SLOT_W     = 3;
    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned IDLE_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0]   IDLE_MAX   = '1;
    localparam logic [SLOT_W-1:0]   SLOT_RESET = 3'd1;
    localparam logic [SAMPLE_W-1:0] WLOW_RESET = 10'd0;
    localparam logic [SAMPLE_W-1:0] WHIGH_RESET = 10'd1023;
    localparam logic [IDLE_W-1:0]   WAIT_RESET = 16'd65535;

    // Slot that feeds each bit of the report map
    localparam logic [SLOT_W-1:0] REPORT_ORDER [SLOT_COUNT] =
        '{3'd5, 3'd7, 3'd6, 3'd4, 3'd2, 3'd1, 3'd0, 3'd3};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT    = 2'd2;

    typedef enum logic {
        CAUSE_CHANGE  = 1'b0,
        CAUSE_TIMEOUT = 1'b1
    } cause_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] flags;
        logic [SLOT_W-1:0]     slot;
        logic [IDLE_W-1:0]     idle;
    } scan_state_t;

    typedef struct packed {
        logic [SLOT_W-1:0]     next_channel;
        logic                  report_valid;
        cause_t                cause;
        logic [SLOT_COUNT-1:0] slot_map;
    } scan_result_t;

endpackage

### hw/rtl/mps_judge.sv
`timescale 1ns / 1ps

module mps_judge (
    input  logic [mps_pkg::SAMPLE_W-1:0] sample,
    input  logic [mps_pkg::SAMPLE_W-1:0] window_low,
    input  logic [mps_pkg::SAMPLE_W-1:0] window_high,
    input  logic [mps_pkg::IDLE_W-1:0]   max_wait,
    input  mps_pkg::scan_state_t         cur,
    output mps_pkg::scan_state_t         nxt,
    output mps_pkg::scan_result_t        res
);
    import mps_pkg::*;

    logic in_window;
    logic was_plugged;
    logic changed;
    logic timeout;

    // Window compare, both bounds strict
    assign in_window   = (sample > window_low) && (sample < window_high);
    assign was_plugged = cur.flags[cur.slot];
    assign changed     = (was_plugged != in_window);
    assign timeout     = (cur.idle > max_wait);

    // Update flags, idle count and slot pointer
    always_comb
    begin
        nxt = cur;
        nxt.flags[cur.slot] = in_window;
        nxt.slot = cur.slot + 3'd1;
        priority if (changed || timeout)
        begin
            nxt.idle = '0;
        end
        else if (cur.idle != IDLE_MAX)
        begin
            nxt.idle = cur.idle + 16'd1;
        end
        else
        begin
            nxt.idle = cur.idle;
        end
    end

    // Build the report from the updated flags
    always_comb
    begin
        res.next_channel = nxt.slot;
        res.report_valid = changed || timeout;
        res.cause        = CAUSE_CHANGE;
        res.slot_map     = '0;
        if (changed || timeout)
        begin
            res.cause = changed ? CAUSE_CHANGE : CAUSE_TIMEOUT;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                res.slot_map[i] = nxt.flags[REPORT_ORDER[i]];
            end
        end
    end

endmodule

### hw/rtl/multichannel_presence_scanner_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample
// output    out        out_valid/ out_stall next_channel, report_valid,
//                                           report_cause, slot_map
// config    in         cfg_we               cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall stays low; a taken transaction passes
// through the input register, then the result register, before its result is on the
// outputs and can be accepted.
// The window compare and flag update are combinational between the two registers.
// Reset clears flags and idle count, points the scan at slot 1, loads defaults.
// A stalled result holds the result register; the input register then holds
// too, and in_stall rises only while both are full.

module multichannel_presence_scanner_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [mps_pkg::SAMPLE_W-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mps_pkg::SLOT_W-1:0]     next_channel,
    output logic                           report_valid,
    output logic                           report_cause,
    output logic [mps_pkg::SLOT_COUNT-1:0] slot_map,
    input  logic                           cfg_we,
    input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mps_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mps_pkg::*;

    logic [SAMPLE_W-1:0] window_low_reg;
    logic [SAMPLE_W-1:0] window_high_reg;
    logic [IDLE_W-1:0]   max_wait_reg;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    scan_state_t         state_reg;
    scan_state_t         state_next;
    scan_result_t        step_res;

    logic                out_valid_reg;
    scan_result_t        result_reg;

    logic                out_free;
    logic                advance;
    logic                in_take;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= WLOW_RESET;
            window_high_reg <= WHIGH_RESET;
            max_wait_reg    <= WAIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LOW:  window_low_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_WINDOW_HIGH: window_high_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_MAX_WAIT:    max_wait_reg    <= cfg_data[IDLE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register: hold while the stage ahead is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
        end
    end

    mps_judge u_judge (
        .sample      (sample_reg),
        .window_low  (window_low_reg),
        .window_high (window_high_reg),
        .max_wait    (max_wait_reg),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    // Scan state: advance once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.flags <= '0;
            state_reg.slot  <= SLOT_RESET;
            state_reg.idle  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_channel = result_reg.next_channel;
    assign report_valid = result_reg.report_valid;
    assign report_cause = logic'(result_reg.cause);
    assign slot_map     = result_reg.slot_map;

    // A processed transaction always lands in the result register
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed transaction did not reach the result register");

    // The reported next slot matches the scan pointer
    a_slot_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.next_channel == state_reg.slot))
        else $error("next_channel out of step with scan pointer");

    // A report always restarts the idle count
    a_report_clears_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_res.report_valid) |=> (state_reg.idle == '0))
        else $error("idle count not cleared by a report");

    // Without a report the cause and map read zero
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.report_valid) |->
            (result_reg.slot_map == '0 && result_reg.cause == CAUSE_CHANGE))
        else $error("non-report result carries cause or map");

    // Input side stalls only with a full input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule

### verif/multichannel_presence_scanner_unit_test.sv
`timescale 1ns / 1ps

module multichannel_presence_scanner_unit_test;

    import mps_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 6_000_000;
    localparam int unsigned PHASE_ITEMS  = 130;
    localparam int unsigned RANDOM_PHASES = 10;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SLOT_W-1:0]     next_channel;
    logic                  report_valid;
    logic                  report_cause;
    logic [SLOT_COUNT-1:0] slot_map;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Shadow of the scanner state and its registers
    logic [SLOT_COUNT-1:0] plugged_q  = '0;
    logic [SLOT_W-1:0]     scan_pos   = SLOT_RESET;
    logic [IDLE_W-1:0]     idle_count = '0;
    logic [SAMPLE_W-1:0]   win_low    = WLOW_RESET;
    logic [SAMPLE_W-1:0]   win_high   = WHIGH_RESET;
    logic [IDLE_W-1:0]     wait_limit = WAIT_RESET;

    scan_result_t expected_reports[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  idle_odds      = 6;
    int unsigned  stall_left     = 0;

    multichannel_presence_scanner_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_channel (next_channel),
        .report_valid (report_valid),
        .report_cause (report_cause),
        .slot_map     (slot_map),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[multichannel_presence_scanner_unit] ERROR");
            $finish;
        end
    end

    // Stall the result side in random bursts
    always @(negedge clk)
    begin
        if (idle_odds == 0)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(1, idle_odds) == 1)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result transaction with the oldest prediction
    always @(posedge clk)
    begin
        scan_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result ch=%0d valid=%0d cause=%0d map=%h",
                         $time, next_channel, report_valid, report_cause, slot_map);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                if (next_channel !== exp_r.next_channel)
                begin
                    $display("%0t: next_channel expected %0d actual %0d",
                             $time, exp_r.next_channel, next_channel);
                    mismatch_count++;
                end
                if (report_valid !== exp_r.report_valid)
                begin
                    $display("%0t: report_valid expected %0d actual %0d",
                             $time, exp_r.report_valid, report_valid);
                    mismatch_count++;
                end
                if (report_cause !== exp_r.cause)
                begin
                    $display("%0t: report_cause expected %0d actual %0d",
                             $time, exp_r.cause, report_cause);
                    mismatch_count++;
                end
                if (slot_map !== exp_r.slot_map)
                begin
                    $display("%0t: slot_map expected %h actual %h",
                             $time, exp_r.slot_map, slot_map);
                    mismatch_count++;
                end
            end
        end
    end

    // Judge one sample against the window and advance the shadow state
    function automatic scan_result_t predict_scan(input logic [SAMPLE_W-1:0] value);
        scan_result_t res;
        logic         was_in;
        logic         now_in;
        res    = '0;
        was_in = plugged_q[scan_pos];
        now_in = (value > win_low) && (value < win_high);
        if (was_in != now_in)
        begin
            plugged_q[scan_pos] = now_in;
            idle_count          = '0;
            res.report_valid    = 1'b1;
            res.cause           = CAUSE_CHANGE;
        end
        else if (idle_count > wait_limit)
        begin
            idle_count       = '0;
            res.report_valid = 1'b1;
            res.cause        = CAUSE_TIMEOUT;
        end
        else if (idle_count != IDLE_MAX)
        begin
            idle_count = idle_count + 1'b1;
        end
        // Map slots into report order
        if (res.report_valid)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                res.slot_map[i] = plugged_q[REPORT_ORDER[i]];
        end
        scan_pos         = scan_pos + 1'b1;
        res.next_channel = scan_pos;
        return res;
    endfunction

    // Pick a sample; with hold set, keep the current slot's plugged state
    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit hold);
        logic                want_in;
        bit                  has_inside;
        logic [SAMPLE_W-1:0] value;
        has_inside = (win_high > win_low + 1);
        want_in    = hold ? plugged_q[scan_pos] : logic'($urandom_range(0, 1));
        if (!hold && $urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 5))
                0: value = '0;
                1: value = '1;
                2: value = win_low;
                3: value = win_low + 1'b1;
                4: value = win_high - 1'b1;
                default: value = win_high;
            endcase
        end
        else if (want_in && has_inside)
            value = SAMPLE_W'($urandom_range(win_low + 1, win_high - 1));
        else if ($urandom_range(0, 1) == 0)
            value = SAMPLE_W'($urandom_range(0, win_low));
        else
            value = SAMPLE_W'($urandom_range(win_high, 1023));
        return value;
    endfunction

    // Send one sample transaction, with an optional gap ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int unsigned gap;
        @(negedge clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
        expected_reports.push_back(predict_scan(value));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW_LOW:  win_low    = value[SAMPLE_W-1:0];
            CFG_WINDOW_HIGH: win_high   = value[SAMPLE_W-1:0];
            CFG_MAX_WAIT:    wait_limit = value;
            default: ;
        endcase
    endtask

    // Write both thresholds with random junk above the used bits
    task automatic set_window(input int unsigned lo, input int unsigned hi);
        logic [CFG_DATA_W-1:0] lo_word;
        logic [CFG_DATA_W-1:0] hi_word;
        lo_word = CFG_DATA_W'($urandom);
        hi_word = CFG_DATA_W'($urandom);
        lo_word[SAMPLE_W-1:0] = SAMPLE_W'(lo);
        hi_word[SAMPLE_W-1:0] = SAMPLE_W'(hi);
        write_reg(CFG_WINDOW_LOW, lo_word);
        write_reg(CFG_WINDOW_HIGH, hi_word);
    endtask

    // Clear every slot by scanning a full round through an empty window
    task automatic clear_slots;
        set_window(1023, 0);
        for (int i = 0; i < SLOT_COUNT; i++)
            send_sample(pick_sample(1'b0));
        drain;
    endtask

    task automatic test_reset_defaults;
        send_sample(10'd0);
        send_sample(10'd1);
        send_sample(10'd1023);
        send_sample(10'd1022);
        send_sample(10'd512);
        send_sample(10'h2AA);
        send_sample(10'h155);
        drain;
    endtask

    task automatic test_window_edges;
        set_window(100, 200);
        send_sample(10'd100);
        send_sample(10'd101);
        send_sample(10'd199);
        send_sample(10'd200);
        send_sample(10'd0);
        send_sample(10'd1023);
        drain;
        // Empty window: nothing reads as plugged
        set_window(500, 501);
        send_sample(10'd500);
        send_sample(10'd501);
        drain;
        set_window(300, 300);
        send_sample(10'd300);
        send_sample(10'd150);
        drain;
    endtask

    task automatic test_idle_timeout;
        clear_slots();
        set_window(0, 1023);
        write_reg(CFG_MAX_WAIT, 16'd0);
        repeat (4) send_sample(10'd0);
        // Change and timeout due together: change wins
        send_sample(10'd0);
        send_sample(10'd500);
        drain;
        write_reg(CFG_MAX_WAIT, 16'd2);
        repeat (6) send_sample(10'd1023);
        drain;
    endtask

    task automatic test_wide_wait;
        int unsigned saved_odds;
        saved_odds = idle_odds;
        idle_odds  = 20;
        clear_slots();
        write_reg(CFG_MAX_WAIT, 16'hFFFF);
        // Stay idle under the widest limit: no timeout fires
        repeat (100) send_sample(pick_sample(1'b0));
        drain;
        write_reg(CFG_MAX_WAIT, 16'hFFFE);
        repeat (3) send_sample(pick_sample(1'b0));
        drain;
        idle_odds = saved_odds;
    endtask

    task automatic test_random_scan;
        int unsigned lo;
        int unsigned hi;
        int unsigned hold_pct;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                lo = 0;
                hi = 1023;
                write_reg(CFG_MAX_WAIT, 16'd0);
            end
            else if (p == 1)
            begin
                lo = 1023;
                hi = 0;
                write_reg(CFG_MAX_WAIT, 16'hFFFF);
            end
            else
            begin
                lo = $urandom_range(0, 1023);
                hi = $urandom_range(0, 1023);
                if (lo > hi && $urandom_range(0, 3) != 0)
                begin
                    lo = lo ^ hi;
                    hi = lo ^ hi;
                    lo = lo ^ hi;
                end
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_MAX_WAIT, CFG_DATA_W'($urandom_range(0, 65535)));
                else
                    write_reg(CFG_MAX_WAIT, CFG_DATA_W'($urandom_range(0, 24)));
            end
            set_window(lo, hi);
            case ($urandom_range(0, 2))
                0: idle_odds = 0;
                1: idle_odds = 3;
                default: idle_odds = 8;
            endcase
            // Hold the last phase free of gaps and stalls
            if (p == RANDOM_PHASES - 1)
                idle_odds = 0;
            hold_pct = $urandom_range(50, 90);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample($urandom_range(1, 100) <= hold_pct));
            drain;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_window_edges();
        test_idle_timeout();
        test_wide_wait();
        test_random_scan();
        drain;
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("[multichannel_presence_scanner_unit] OK");
        else
            $display("[multichannel_presence_scanner_unit] ERROR");
        $finish;
    end

endmodule
